[sv/tps_pkg.sv]
// Package for the periodic timer scheduler.
// Holds payload structs, request/status/kind codes, the table entry layout and time compare.
// No dependencies.
package tps_pkg;

  localparam int TPS_TABLE_DEPTH = 16;
  localparam logic [63:0] TPS_INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    REQ_ADD_ONESHOT  = 3'd0,
    REQ_ADD_PERIODIC = 3'd1,
    REQ_CHANGE       = 3'd2,
    REQ_REMOVE       = 3'd3,
    REQ_PROCESS      = 3'd4,
    REQ_QUERY        = 3'd5
  } tps_req_t;

  typedef enum logic [1:0] {
    ST_GOOD      = 2'd0,
    ST_BAD_IVAL  = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } tps_status_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_FIRED  = 2'd1,
    KIND_NEXT   = 2'd2
  } tps_kind_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [63:0] now_time;
    logic signed [63:0] time_value;
    logic               has_base;
    logic [61:0]        interval_ticks;
    logic               miss_policy;
    logic [31:0]        timer_id;
  } tps_in_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [1:0]         status;
    logic [31:0]        out_id;
    logic signed [63:0] next_time;
    logic               last;
  } tps_out_t;

  // One table entry as stored in RAM
  typedef struct packed {
    logic        policy;
    logic [61:0] period;
    logic [63:0] due;
    logic [31:0] id;
  } tps_entry_t;

  // Control/status between sequencer and remainder unit
  typedef struct packed {
    logic busy;
    logic done;
  } tps_div_stat_t;

  // Signed 64-bit less-than on raw bits
  function automatic logic time_lt(input logic [63:0] a, input logic [63:0] b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

[sv/tps_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/tps_div.sv]
// Bit-serial remainder unit: 64-bit magnitude modulo a 62-bit nonzero period.
// Depends on tps_pkg; one dividend bit per cycle.
module tps_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [63:0]           dividend,
  input  logic [61:0]           divisor,
  output tps_pkg::tps_div_stat_t stat,
  output logic [61:0]           rem
);
  import tps_pkg::*;

  logic [63:0] dvd_r, dvd_nxt;
  logic [61:0] div_r, div_nxt;
  logic [61:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [62:0] trial;

  always_comb begin
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, dvd_r[63]};
    if (start) begin
      dvd_nxt  = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in one bit, subtract when it fits
      if (trial >= {1'b0, div_r}) begin
        trial = trial - {1'b0, div_r};
      end
      rem_nxt = trial[61:0];
      dvd_nxt = {dvd_r[62:0], 1'b0};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign rem       = rem_r;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("remainder done while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n) start |=> busy_r)
    else $error("remainder unit did not start");
  a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> $past(busy_r))
    else $error("done without a run");

endmodule

[sv/periodic_timer_scheduler_top.sv]
// Top level of the periodic timer scheduler: request sequencer, entry RAM, remainder unit.
// Depends on tps_pkg, tps_ram and tps_div.
//
//   channel | ports                       | payload
//   input   | in_valid / in_ready         | in_data  (tps_in_t)
//   output  | out_valid / out_ready       | out_data (tps_out_t)
//
// One request at a time; in_ready is high only while the sequencer is idle.
// Table walks use a read state and a check state per slot (registered RAM read);
// add/change/remove scan the table, plus base alignment in the remainder unit when a base is given.
// Process: a marking pass, then per fired entry a best-entry scan plus any realignment,
// then an earliest-due scan. Output stalls hold the sequencer at a result.
// Reset (synchronous) clears valid/pending bits and the id counter; no clearing pass.
module periodic_timer_scheduler_top #(
  parameter int TABLE_DEPTH = tps_pkg::TPS_TABLE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tps_pkg::tps_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tps_pkg::tps_out_t out_data
);
  import tps_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_SCAN_RD, S_SCAN_CHK, S_DIV_START, S_DIV_WAIT, S_DIV_FIN,
    S_WRITE, S_STATUS, S_MARK_RD, S_MARK_CHK, S_BEST_RD, S_BEST_CHK, S_FIRE,
    S_UPD, S_EARLY_RD, S_EARLY_CHK, S_NEXT
  } state_t;

  state_t            state_r, state_nxt;
  logic [2:0]        req_r, req_nxt;
  logic [63:0]       now_r, now_nxt;
  logic [63:0]       tv_r, tv_nxt;
  logic              hb_r, hb_nxt;
  logic [61:0]       per_r, per_nxt;
  logic              pol_r, pol_nxt;
  logic [31:0]       tid_r, tid_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [IW-1:0]     slot_r, slot_nxt;
  logic              found_r, found_nxt;
  logic [63:0]       due_r, due_nxt;
  logic [31:0]       id_r, id_nxt;
  logic [63:0]       base_r, base_nxt;
  logic              neg_r, neg_nxt;
  logic [61:0]       delay_r, delay_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [31:0]       id_cnt_r, id_cnt_nxt;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [TABLE_DEPTH-1:0] pend_r, pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  tps_out_t          out_data_r, out_data_nxt;

  logic              ram_we;
  tps_entry_t        wr_entry;
  logic [$bits(tps_entry_t)-1:0] ram_rdata;
  tps_entry_t        rd;
  logic              div_start;
  logic [63:0]       diff, mag;
  tps_div_stat_t     div_stat;
  logic [61:0]       div_rem;
  logic              can_emit;
  logic              is_add, hit, take;

  assign rd = tps_entry_t'(ram_rdata);
  assign wr_entry = '{policy: pol_r, period: per_r, due: due_r, id: id_r};
  assign ram_we = (state_r == S_WRITE);
  assign diff = now_r - base_r;
  assign mag  = diff[63] ? (64'd0 - diff) : diff;
  assign div_start = (state_r == S_DIV_START);
  assign can_emit = !out_valid_r || out_ready;
  assign is_add = (req_r == REQ_ADD_ONESHOT) || (req_r == REQ_ADD_PERIODIC);

  tps_ram #(.WIDTH($bits(tps_entry_t)), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (wr_entry),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  tps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag),
    .divisor  (per_r),
    .stat     (div_stat),
    .rem      (div_rem)
  );

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    now_nxt       = now_r;
    tv_nxt        = tv_r;
    hb_nxt        = hb_r;
    per_nxt       = per_r;
    pol_nxt       = pol_r;
    tid_nxt       = tid_r;
    idx_nxt       = idx_r;
    slot_nxt      = slot_r;
    found_nxt     = found_r;
    due_nxt       = due_r;
    id_nxt        = id_r;
    base_nxt      = base_r;
    neg_nxt       = neg_r;
    delay_nxt     = delay_r;
    status_nxt    = status_r;
    id_cnt_nxt    = id_cnt_r;
    valid_nxt     = valid_r;
    pend_nxt      = pend_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    hit           = 1'b0;
    take          = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data.req_type;
          now_nxt   = in_data.now_time;
          tv_nxt    = in_data.time_value;
          hb_nxt    = in_data.has_base;
          per_nxt   = in_data.interval_ticks;
          pol_nxt   = in_data.miss_policy;
          tid_nxt   = in_data.timer_id;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        idx_nxt   = '0;
        found_nxt = 1'b0;
        case (req_r)
          REQ_ADD_ONESHOT, REQ_REMOVE: state_nxt = S_SCAN_RD;
          REQ_ADD_PERIODIC, REQ_CHANGE: begin
            if (per_r == '0) begin
              status_nxt = ST_BAD_IVAL;
              state_nxt  = S_STATUS;
            end else begin
              state_nxt = S_SCAN_RD;
            end
          end
          REQ_PROCESS: state_nxt = S_MARK_RD;
          default: begin
            due_nxt   = TPS_INT64_MAX;
            state_nxt = S_EARLY_RD;
          end
        endcase
      end
      S_SCAN_RD: state_nxt = S_SCAN_CHK;
      S_SCAN_CHK: begin
        hit = is_add ? !valid_r[idx_r] : (valid_r[idx_r] && rd.id == tid_r);
        if (hit) begin
          slot_nxt   = idx_r;
          status_nxt = ST_GOOD;
          if (is_add) begin
            id_cnt_nxt = id_cnt_r + 32'd1;
            id_nxt     = id_cnt_r + 32'd1;
          end else begin
            id_nxt = tid_r;
          end
          case (req_r)
            REQ_ADD_ONESHOT: begin
              due_nxt   = tv_r;
              per_nxt   = '0;
              pol_nxt   = 1'b0;
              state_nxt = S_WRITE;
            end
            REQ_REMOVE: begin
              valid_nxt[idx_r] = 1'b0;
              pend_nxt[idx_r]  = 1'b0;
              state_nxt        = S_STATUS;
            end
            default: begin
              if (hb_r) begin
                base_nxt  = tv_r;
                state_nxt = S_DIV_START;
              end else begin
                due_nxt   = now_r + {2'b00, per_r};
                state_nxt = S_WRITE;
              end
            end
          endcase
        end else if (idx_r == LAST_IDX) begin
          status_nxt = is_add ? ST_FULL : ST_NOT_FOUND;
          state_nxt  = S_STATUS;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_DIV_START: begin
        neg_nxt   = diff[63];
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_stat.done) begin
          delay_nxt = (neg_r && div_rem != '0) ? (per_r - div_rem) : div_rem;
          state_nxt = S_DIV_FIN;
        end
      end
      S_DIV_FIN: begin
        due_nxt   = now_r + {2'b00, per_r} - {2'b00, delay_r};
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        valid_nxt[slot_r] = 1'b1;
        pend_nxt[slot_r]  = 1'b0;
        idx_nxt   = '0;
        found_nxt = 1'b0;
        state_nxt = (req_r == REQ_PROCESS) ? S_BEST_RD : S_STATUS;
      end
      S_STATUS: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{result_kind: KIND_STATUS, status: status_r,
                            out_id: (is_add && status_r == ST_GOOD) ? id_r : 32'd0,
                            next_time: 64'sd0, last: 1'b1};
          state_nxt = S_IDLE;
        end
      end
      S_MARK_RD: state_nxt = S_MARK_CHK;
      S_MARK_CHK: begin
        pend_nxt[idx_r] = valid_r[idx_r] && !time_lt(now_r, rd.due);
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = S_BEST_RD;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_MARK_RD;
        end
      end
      S_BEST_RD: state_nxt = S_BEST_CHK;
      S_BEST_CHK: begin
        // earliest due, then lower id; strict compare keeps the lower slot
        take = pend_r[idx_r] && (!found_r || time_lt(rd.due, due_r) ||
               (rd.due == due_r && rd.id < id_r));
        if (take) begin
          found_nxt = 1'b1;
          slot_nxt  = idx_r;
          due_nxt   = rd.due;
          id_nxt    = rd.id;
          per_nxt   = rd.period;
          pol_nxt   = rd.policy;
        end
        if (idx_r == LAST_IDX) begin
          idx_nxt = '0;
          if (found_r || take) begin
            state_nxt = S_FIRE;
          end else begin
            due_nxt   = TPS_INT64_MAX;
            state_nxt = S_EARLY_RD;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_BEST_RD;
        end
      end
      S_FIRE: begin
        if (can_emit) begin
          out_valid_nxt    = 1'b1;
          out_data_nxt     = '{result_kind: KIND_FIRED, status: ST_GOOD, out_id: id_r,
                               next_time: due_r, last: 1'b0};
          pend_nxt[slot_r] = 1'b0;
          if (per_r == '0) begin
            valid_nxt[slot_r] = 1'b0;
            idx_nxt   = '0;
            found_nxt = 1'b0;
            state_nxt = S_BEST_RD;
          end else begin
            due_nxt   = due_r + {2'b00, per_r};
            state_nxt = S_UPD;
          end
        end
      end
      S_UPD: begin
        if (time_lt(due_r, now_r)) begin
          if (pol_r) begin
            base_nxt  = due_r;
            state_nxt = S_DIV_START;
          end else begin
            due_nxt   = now_r + {2'b00, per_r};
            state_nxt = S_WRITE;
          end
        end else begin
          state_nxt = S_WRITE;
        end
      end
      S_EARLY_RD: state_nxt = S_EARLY_CHK;
      S_EARLY_CHK: begin
        if (valid_r[idx_r] && time_lt(rd.due, due_r)) begin
          due_nxt = rd.due;
        end
        if (idx_r == LAST_IDX) begin
          state_nxt = S_NEXT;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_EARLY_RD;
        end
      end
      S_NEXT: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{result_kind: KIND_NEXT, status: ST_GOOD, out_id: 32'd0,
                            next_time: due_r, last: 1'b1};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      pend_r      <= '0;
      id_cnt_r    <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      pend_r      <= pend_nxt;
      id_cnt_r    <= id_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
    end
    req_r      <= req_nxt;
    now_r      <= now_nxt;
    tv_r       <= tv_nxt;
    hb_r       <= hb_nxt;
    per_r      <= per_nxt;
    pol_r      <= pol_nxt;
    tid_r      <= tid_nxt;
    idx_r      <= idx_nxt;
    slot_r     <= slot_nxt;
    due_r      <= due_nxt;
    id_r       <= id_nxt;
    base_r     <= base_nxt;
    neg_r      <= neg_nxt;
    delay_r    <= delay_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
